@@ design/maf_pkg.sv @@
// Package: shared constants, types and helpers for the ADC averager framer.
package maf_pkg;
  localparam int unsigned ChannelsDef  = 8;
  localparam int unsigned CountBitsDef = 24;
  localparam int unsigned ReadingBits  = 12;
  localparam int unsigned AvgBits      = 12;

  localparam logic OpSample = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic [7:0]  frame_first_byte;
    logic [7:0]  frame_second_byte;
    logic [3:0]  tenths_digit;
    logic [15:0] segment_word;
    logic        last;
  } result_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      4'd10:   code = 8'h77;
      default: code = 8'h00;
    endcase
    return code;
  endfunction
endpackage

@@ design/maf_lane.sv @@
// Lane: per-channel saturating sum and sample count.
module maf_lane #(
  parameter int unsigned CountBits = maf_pkg::CountBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   add_i,
  input  logic                                   clear_i,
  input  logic [maf_pkg::ReadingBits-1:0]        reading_i,
  output logic [maf_pkg::ReadingBits+CountBits-1:0] sum_o,
  output logic [CountBits-1:0]                   count_o
);
  import maf_pkg::*;
  localparam int unsigned SumBits = ReadingBits + CountBits;

  logic [SumBits-1:0]   sum_q;
  logic [CountBits-1:0] count_q;
  logic                 sat;

  assign sat = &count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (add_i && !sat) begin
      sum_q   <= sum_q + SumBits'(reading_i);
      count_q <= count_q + 1'b1;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;
endmodule

@@ design/maf_div.sv @@
// Divider: restoring division of a lane sum by its count, one quotient bit per cycle.
module maf_div #(
  parameter int unsigned CountBits = maf_pkg::CountBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [maf_pkg::ReadingBits+CountBits-1:0] sum_i,
  input  logic [CountBits-1:0]                      count_i,
  output logic                                      done_o,
  output logic [maf_pkg::AvgBits-1:0]               avg_o
);
  import maf_pkg::*;
  localparam int unsigned SumBits = ReadingBits + CountBits;
  localparam int unsigned CntW    = $clog2(SumBits + 1);

  logic [SumBits-1:0]   num_q, num_d;
  logic [CountBits:0]   rem_q, rem_d;
  logic [CountBits-1:0] den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, zero_q;
  logic [CountBits:0]   trial;

  // quotient shifts into num_q as the dividend shifts out
  always_comb begin
    trial = {rem_q[CountBits-1:0], num_q[SumBits-1]};
    rem_d = trial;
    num_d = {num_q[SumBits-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      num_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= sum_i;
      rem_q  <= '0;
      den_q  <= count_i;
      zero_q <= (count_i == '0);
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign avg_o = zero_q ? '0 : num_q[AvgBits-1:0];
endmodule

@@ design/multichannel_adc_averager_framer.sv @@
// Top level: ADC channel averager with per-lane accumulators and tick-time framer.
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o| opcode_i, channel_mask_i, reading_ch0_i..7_i
//  out     | out_valid_o/out_stall_i | channel_index_o .. last_o
// A sample beat is taken every cycle while idle; lanes accumulate in the same cycle.
// A tick walks enabled channels; each in turn goes through the shared bit-serial
// divider, then is emitted. Input stalls during the walk and clear.
// Reset clears mask, sums and counts. A stalled result holds in the out register.
module multichannel_adc_averager_framer #(
  parameter int unsigned CHANNELS   = maf_pkg::ChannelsDef,
  parameter int unsigned COUNT_BITS = maf_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  channel_mask_i,
  input  logic [11:0] reading_ch0_i,
  input  logic [11:0] reading_ch1_i,
  input  logic [11:0] reading_ch2_i,
  input  logic [11:0] reading_ch3_i,
  input  logic [11:0] reading_ch4_i,
  input  logic [11:0] reading_ch5_i,
  input  logic [11:0] reading_ch6_i,
  input  logic [11:0] reading_ch7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  channel_index_o,
  output logic [7:0]  frame_first_byte_o,
  output logic [7:0]  frame_second_byte_o,
  output logic [3:0]  tenths_digit_o,
  output logic [15:0] segment_word_o,
  output logic        last_o
);
  import maf_pkg::*;
  localparam int unsigned SumBits = ReadingBits + COUNT_BITS;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StDiv  = 5'b00100,
    StEmit = 5'b01000,
    StWait = 5'b10000
  } state_e;

  state_e state_q;
  logic [7:0]  mask_q;
  logic [7:0]  pend_q;
  logic [2:0]  ch_q;
  logic [11:0] reading [8];
  logic [SumBits-1:0]    sum   [CHANNELS];
  logic [COUNT_BITS-1:0] count [CHANNELS];
  logic in_acc, out_acc, clear;
  logic emit;
  logic [SumBits-1:0]    sel_sum;
  logic [COUNT_BITS-1:0] sel_count;
  logic div_start, div_done;
  logic [AvgBits-1:0] avg;
  logic [18:0] prod_q;
  logic [11:0] avg_q;
  logic [3:0]  digit;
  logic [2:0]  next_ch;
  logic        found;
  logic [7:0]  lane_mask;

  assign reading = '{reading_ch0_i, reading_ch1_i, reading_ch2_i, reading_ch3_i,
                     reading_ch4_i, reading_ch5_i, reading_ch6_i, reading_ch7_i};

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign emit       = (state_q == StWait) && (!out_valid_o || out_acc);

  always_comb begin
    lane_mask = '0;
    for (int i = 0; i < CHANNELS; i++) lane_mask[i] = channel_mask_i[i];
  end

  assign clear = (state_q == StScan) && (pend_q == '0);

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    maf_lane #(.CountBits(COUNT_BITS)) u_lane (
      .clk_i, .rst_ni,
      .add_i    (in_acc && opcode_i == OpSample && lane_mask[g]),
      .clear_i  (clear),
      .reading_i(reading[g]),
      .sum_o    (sum[g]),
      .count_o  (count[g])
    );
  end

  always_comb begin
    found   = 1'b0;
    next_ch = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_q[i]) begin
        found   = 1'b1;
        next_ch = 3'(i);
      end
    end
  end

  always_comb begin
    sel_sum   = '0;
    sel_count = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (next_ch == 3'(i)) begin
        sel_sum   = sum[i];
        sel_count = count[i];
      end
    end
  end

  assign div_start = (state_q == StScan) && found;

  maf_div #(.CountBits(COUNT_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .sum_i  (sel_sum),
    .count_i(sel_count),
    .done_o (div_done),
    .avg_o  (avg)
  );

  // avg*100/4095/10 == floor(avg*100/40950)
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (prod_q >= 19'(k * 40950)) digit = 4'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mask_q      <= '0;
      pend_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (opcode_i == OpSample) begin
              mask_q <= lane_mask;
            end else begin
              pend_q  <= mask_q;
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (found) begin
            state_q <= StDiv;
          end else begin
            mask_q  <= '0;
            state_q <= StIdle;
          end
        end
        StDiv: if (div_done) state_q <= StEmit;
        StEmit: state_q <= StWait;
        StWait: begin
          if (emit) begin
            pend_q[ch_q] <= 1'b0;
            state_q      <= StScan;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) ch_q <= next_ch;
    if (state_q == StDiv && div_done) begin
      avg_q  <= avg;
      prod_q <= 19'(avg) * 19'd100;
    end
    if (emit) begin
      channel_index_o     <= ch_q;
      frame_first_byte_o  <= {ch_q, avg_q[11:7]};
      frame_second_byte_o <= {avg_q[6:0], 1'b0};
      tenths_digit_o      <= digit;
      segment_word_o      <= {seg_code({1'b0, ch_q}), seg_code(digit)};
      last_o              <= ((pend_q & ~(8'd1 << ch_q)) == '0);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_index_o))
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == StScan && pend_q != '0)
    else $error("divider started without pending channel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tenths_digit_o <= 4'd10)
    else $error("digit out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> state_q == StIdle)
    else $error("clear outside end of walk");
endmodule
